// ----- hw/rtl/battery_level_tracker_macros.svh -----
// Assertion macros used by the battery level tracker top level
`ifndef BATTERY_LEVEL_TRACKER_MACROS_SVH
`define BATTERY_LEVEL_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery level tracker: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define BLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("battery level tracker: next-cycle check failed");

`endif

// ----- hw/rtl/blt_pkg.sv -----
// Package: types, codes and constants of the battery level tracker
`default_nettype none

package blt_pkg;

    localparam int MV_BITS_DEF  = 13;
    localparam int HYST_BITS    = 10;
    localparam int STATUS_BITS  = 3;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [1:0] {
        LVL_UNKNOWN = 2'd0,
        LVL_LOW     = 2'd1,
        LVL_MEDIUM  = 2'd2,
        LVL_HIGH    = 2'd3
    } level_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_THR  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_THR = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HYST     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHUT_THR = 2'd3;

    localparam int LOW_THR_RESET  = 3400;
    localparam int HIGH_THR_RESET = 3950;
    localparam int HYST_RESET     = 100;
    localparam int SHUT_THR_RESET = 3000;

endpackage

`default_nettype wire

// ----- hw/rtl/blt_in_if.sv -----
// Interface: sample channel of the battery level tracker
`default_nettype none

interface blt_in_if #(
    parameter int MV_BITS = blt_pkg::MV_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [MV_BITS-1:0] sample_mv;
    logic               charging_now;
    logic               usb_present;

    modport source (output valid, output sample_mv, output charging_now,
                    output usb_present, input ready);
    modport sink   (input valid, input sample_mv, input charging_now,
                    input usb_present, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/blt_out_if.sv -----
// Interface: result channel of the battery level tracker
`default_nettype none

interface blt_out_if #(
    parameter int MV_BITS = blt_pkg::MV_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [MV_BITS-1:0]                 tracked_mv;
    logic [1:0]                         charge_level;
    logic [blt_pkg::STATUS_BITS-1:0]    status_code;
    logic                               charging_out;
    logic                               usb_out;
    logic                               shutdown_needed;

    modport source (output valid, output tracked_mv, output charge_level,
                    output status_code, output charging_out, output usb_out,
                    output shutdown_needed, input ready);
    modport sink   (input valid, input tracked_mv, input charge_level,
                    input status_code, input charging_out, input usb_out,
                    input shutdown_needed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/blt_cfg_regs.sv -----
// Configuration register bank: thresholds and hysteresis band
`default_nettype none

module blt_cfg_regs #(
    parameter int MV_BITS = blt_pkg::MV_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [blt_pkg::CFG_IDX_BITS-1:0]  index,
    input  logic [MV_BITS-1:0]                wdata,
    output logic [MV_BITS-1:0]                low_thr,
    output logic [MV_BITS-1:0]                high_thr,
    output logic [blt_pkg::HYST_BITS-1:0]     hyst,
    output logic [MV_BITS-1:0]                shut_thr
);
    import blt_pkg::*;

    logic [MV_BITS-1:0]   low_thr_reg;
    logic [MV_BITS-1:0]   high_thr_reg;
    logic [HYST_BITS-1:0] hyst_reg;
    logic [MV_BITS-1:0]   shut_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= MV_BITS'(LOW_THR_RESET);
            high_thr_reg <= MV_BITS'(HIGH_THR_RESET);
            hyst_reg     <= HYST_BITS'(HYST_RESET);
            shut_thr_reg <= MV_BITS'(SHUT_THR_RESET);
        end
        else if (wr_en)
        begin
            case (index)
                CFG_LOW_THR:  low_thr_reg  <= wdata;
                CFG_HIGH_THR: high_thr_reg <= wdata;
                CFG_HYST:     hyst_reg     <= wdata[HYST_BITS-1:0];
                CFG_SHUT_THR: shut_thr_reg <= wdata;
                default:      ;
            endcase
        end
    end

    assign low_thr  = low_thr_reg;
    assign high_thr = high_thr_reg;
    assign hyst     = hyst_reg;
    assign shut_thr = shut_thr_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/blt_classify.sv -----
// Voltage tracking, charge-level classification, status and shutdown flag for one sample
`default_nettype none

module blt_classify #(
    parameter int MV_BITS = blt_pkg::MV_BITS_DEF
) (
    input  logic [MV_BITS-1:0]               sample_mv,
    input  logic                             charging,
    input  logic [MV_BITS-1:0]               held_voltage,
    input  blt_pkg::level_t                  held_level,
    input  logic [MV_BITS-1:0]               low_thr,
    input  logic [MV_BITS-1:0]               high_thr,
    input  logic [blt_pkg::HYST_BITS-1:0]    hyst,
    input  logic [MV_BITS-1:0]               shut_thr,
    output logic [MV_BITS-1:0]               voltage,
    output blt_pkg::level_t                  level,
    output logic [blt_pkg::STATUS_BITS-1:0]  status,
    output logic                             shutdown
);
    import blt_pkg::*;

    logic [MV_BITS:0] v_ext;
    logic [MV_BITS:0] low_ext;
    logic [MV_BITS:0] high_ext;
    logic [MV_BITS:0] hyst_ext;
    logic [MV_BITS:0] low_plus;
    logic [MV_BITS:0] high_plus;
    logic [MV_BITS:0] low_minus;
    logic [MV_BITS:0] high_minus;
    logic             below_low_band;
    logic             below_high_band;
    logic             take_sample;
    level_t           plain_level;

    assign take_sample = (held_voltage == '0) || charging || (sample_mv < held_voltage);

    assign v_ext      = {1'b0, voltage};
    assign low_ext    = {1'b0, low_thr};
    assign high_ext   = {1'b0, high_thr};
    assign hyst_ext   = (MV_BITS+1)'(hyst);
    assign low_plus   = low_ext + hyst_ext;
    assign high_plus  = high_ext + hyst_ext;
    assign low_minus  = low_ext - hyst_ext;
    assign high_minus = high_ext - hyst_ext;

    assign below_low_band  = (hyst_ext <= low_ext) && (v_ext <= low_minus);
    assign below_high_band = (hyst_ext <= high_ext) && (v_ext <= high_minus);

    always_comb
    begin
        if (sample_mv == '0)
            voltage = '0;
        else if (take_sample)
            voltage = sample_mv;
        else
            voltage = held_voltage;
    end

    always_comb
    begin
        if (voltage == '0)
            plain_level = LVL_UNKNOWN;
        else if (voltage <= low_thr)
            plain_level = LVL_LOW;
        else if (voltage >= high_thr)
            plain_level = LVL_HIGH;
        else
            plain_level = LVL_MEDIUM;
    end

    always_comb
    begin
        if (sample_mv == '0)
            level = LVL_UNKNOWN;
        else if (!charging)
            level = plain_level;
        else
        begin
            case (held_level)
                LVL_LOW:
                    level = (v_ext >= low_plus) ? LVL_MEDIUM : LVL_LOW;
                LVL_MEDIUM:
                    if (below_low_band)
                        level = LVL_LOW;
                    else if (v_ext >= high_plus)
                        level = LVL_HIGH;
                    else
                        level = LVL_MEDIUM;
                LVL_HIGH:
                    level = below_high_band ? LVL_MEDIUM : LVL_HIGH;
                default:
                    level = plain_level;
            endcase
        end
    end

    assign status   = {charging && (level != LVL_UNKNOWN), level};
    assign shutdown = !charging && (voltage != '0) && (voltage <= shut_thr);

endmodule

`default_nettype wire

// ----- hw/rtl/battery_level_tracker.sv -----
// Top level: battery voltage tracker and charge-level classifier
//
// Samples arrive on the samples channel (valid/ready); each accepted beat
// gives exactly one beat on the results channel, in order. Thresholds and
// the hysteresis band are set through the write port (cfg_wr_en, cfg_index,
// cfg_wdata) while no sample is in flight; writes take effect at once.
// An accepted beat is held in the input register, then the classifier updates
// the tracked voltage and level and loads the result register, whose valid flag
// drives results.valid. One beat is taken every cycle while the result register
// is not stalled by results.ready; the rate is set by the single classify step
// between the input and result registers, which also updates the tracked state.
// When results.ready is low the result register holds its beat and the input
// register still takes one more beat; samples.ready then drops until the
// receiver drains. Reset clears both valid flags, the tracked voltage and the
// level (unknown), and restores the threshold reset values.
`default_nettype none

`include "battery_level_tracker_macros.svh"

module battery_level_tracker #(
    parameter int MV_BITS = blt_pkg::MV_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [blt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [MV_BITS-1:0]                cfg_wdata,
    blt_in_if.sink                            samples,
    blt_out_if.source                         results
);
    import blt_pkg::*;

    logic [MV_BITS-1:0]     low_thr;
    logic [MV_BITS-1:0]     high_thr;
    logic [HYST_BITS-1:0]   hyst;
    logic [MV_BITS-1:0]     shut_thr;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [MV_BITS-1:0]     in_sample_reg;
    logic                   in_chg_reg;
    logic                   in_usb_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [MV_BITS-1:0]     res_mv_reg;
    level_t                 res_level_reg;
    logic [STATUS_BITS-1:0] res_status_reg;
    logic                   res_chg_reg;
    logic                   res_usb_reg;
    logic                   res_shut_reg;

    logic [MV_BITS-1:0]     held_voltage_reg;
    logic [MV_BITS-1:0]     held_voltage_next;
    level_t                 held_level_reg;
    level_t                 held_level_next;
    logic [STATUS_BITS-1:0] status_next;
    logic                   shut_next;

    logic                   advance;
    logic                   take_in;

    blt_cfg_regs #(
        .MV_BITS (MV_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .index    (cfg_index),
        .wdata    (cfg_wdata),
        .low_thr  (low_thr),
        .high_thr (high_thr),
        .hyst     (hyst),
        .shut_thr (shut_thr)
    );

    blt_classify #(
        .MV_BITS (MV_BITS)
    ) u_classify (
        .sample_mv    (in_sample_reg),
        .charging     (in_chg_reg),
        .held_voltage (held_voltage_reg),
        .held_level   (held_level_reg),
        .low_thr      (low_thr),
        .high_thr     (high_thr),
        .hyst         (hyst),
        .shut_thr     (shut_thr),
        .voltage      (held_voltage_next),
        .level        (held_level_next),
        .status       (status_next),
        .shutdown     (shut_next)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign take_in       = samples.valid && samples.ready;

    always_comb
    begin
        if (samples.ready)
            in_valid_next = samples.valid;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            held_voltage_reg <= '0;
            held_level_reg   <= LVL_UNKNOWN;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                held_voltage_reg <= held_voltage_next;
                held_level_reg   <= held_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_sample_reg <= samples.sample_mv;
            in_chg_reg    <= samples.charging_now;
            in_usb_reg    <= samples.usb_present;
        end
        if (advance)
        begin
            res_mv_reg     <= held_voltage_next;
            res_level_reg  <= held_level_next;
            res_status_reg <= status_next;
            res_chg_reg    <= in_chg_reg;
            res_usb_reg    <= in_usb_reg;
            res_shut_reg   <= shut_next;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.tracked_mv      = res_mv_reg;
    assign results.charge_level    = res_level_reg;
    assign results.status_code     = res_status_reg;
    assign results.charging_out    = res_chg_reg;
    assign results.usb_out         = res_usb_reg;
    assign results.shutdown_needed = res_shut_reg;

    `BLT_ASSERT_NEXT(a_invalid_clears, clk, rst_n, advance && (in_sample_reg == '0), (held_voltage_reg == '0) && (held_level_reg == LVL_UNKNOWN))
    `BLT_ASSERT_NOW(a_level_matches_mv, clk, rst_n, out_valid_reg, (res_mv_reg == '0) == (res_level_reg == LVL_UNKNOWN))
    `BLT_ASSERT_NEXT(a_discharge_no_rise, clk, rst_n, advance && !in_chg_reg && (in_sample_reg != '0) && (held_voltage_reg != '0), held_voltage_reg <= $past(held_voltage_reg))
    `BLT_ASSERT_NOW(a_shutdown_discharging, clk, rst_n, out_valid_reg && res_shut_reg, !res_chg_reg && (res_mv_reg != '0))
    `BLT_ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(in_sample_reg))

endmodule

`default_nettype wire

// ----- tb/sv/battery_level_tracker_test.sv -----
// Self-checking testbench of the battery level tracker: predicted readings, random stalls
`default_nettype none

module battery_level_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import blt_pkg::*;

    localparam int MVB             = MV_BITS_DEF;
    localparam int MV_MAX          = (1 << MVB) - 1;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_BEATS     = 140;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 100;

    typedef logic [MVB-1:0] mv_t;

    typedef struct packed {
        mv_t        tracked;
        level_t     level;
        logic [2:0] status;
        logic       chg;
        logic       usb;
        logic       shut;
    } reading_t;

    class charge_level_book;
        mv_t            low_thr;
        mv_t            high_thr;
        logic [9:0]     hyst;
        mv_t            shut_thr;
        mv_t            held_mv;
        level_t         held_level;
        reading_t       expected_readings[$];
        int             errors;

        function new();
            low_thr    = mv_t'(LOW_THR_RESET);
            high_thr   = mv_t'(HIGH_THR_RESET);
            hyst       = 10'(HYST_RESET);
            shut_thr   = mv_t'(SHUT_THR_RESET);
            held_mv    = '0;
            held_level = LVL_UNKNOWN;
            errors     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, mv_t value);
            case (idx)
                CFG_LOW_THR:  low_thr  = value;
                CFG_HIGH_THR: high_thr = value;
                CFG_HYST:     hyst     = value[9:0];
                CFG_SHUT_THR: shut_thr = value;
                default:      ;
            endcase
        endfunction

        function level_t threshold_level(mv_t mv);
            if (mv == 0)
                return LVL_UNKNOWN;
            if (mv <= low_thr)
                return LVL_LOW;
            if (mv >= high_thr)
                return LVL_HIGH;
            return LVL_MEDIUM;
        endfunction

        function bit dropped_past(mv_t mv, mv_t thr);
            return int'(hyst) <= int'(thr) && int'(mv) <= int'(thr) - int'(hyst);
        endfunction

        function level_t charging_level(mv_t mv, level_t prev);
            if (mv == 0)
                return LVL_UNKNOWN;
            case (prev)
                LVL_LOW:
                    return (int'(mv) >= int'(low_thr) + int'(hyst)) ? LVL_MEDIUM : LVL_LOW;
                LVL_MEDIUM:
                begin
                    if (dropped_past(mv, low_thr))
                        return LVL_LOW;
                    if (int'(mv) >= int'(high_thr) + int'(hyst))
                        return LVL_HIGH;
                    return LVL_MEDIUM;
                end
                LVL_HIGH:
                    return dropped_past(mv, high_thr) ? LVL_MEDIUM : LVL_HIGH;
                default:
                    return threshold_level(mv);
            endcase
        endfunction

        function void note_sample(mv_t mv, logic chg, logic usb);
            reading_t r;
            if (mv == 0)
            begin
                held_mv    = '0;
                held_level = LVL_UNKNOWN;
            end
            else
            begin
                if (held_mv == 0 || chg || mv < held_mv)
                    held_mv = mv;
                held_level = chg ? charging_level(held_mv, held_level)
                                 : threshold_level(held_mv);
            end
            r.tracked = held_mv;
            r.level   = held_level;
            r.status  = {chg && held_level != LVL_UNKNOWN, held_level};
            r.chg     = chg;
            r.usb     = usb;
            r.shut    = !chg && held_mv != 0 && held_mv <= shut_thr;
            expected_readings.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("%0t ns mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                report("result beat with no expectation waiting");
                return;
            end
            want = expected_readings.pop_front();
            compare_field("tracked_mv", 16'(got.tracked), 16'(want.tracked));
            compare_field("charge_level", 16'(got.level), 16'(want.level));
            compare_field("status_code", 16'(got.status), 16'(want.status));
            compare_field("charging_out", 16'(got.chg), 16'(want.chg));
            compare_field("usb_out", 16'(got.usb), 16'(want.usb));
            compare_field("shutdown_needed", 16'(got.shut), 16'(want.shut));
        endtask

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    mv_t                     cfg_wdata;

    blt_in_if  #(.MV_BITS(MVB)) in_ch ();
    blt_out_if #(.MV_BITS(MVB)) out_ch ();

    battery_level_tracker #(.MV_BITS(MVB)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .samples   (in_ch),
        .results   (out_ch)
    );

    charge_level_book book = new();

    int   send_idle_pct = 19;
    int   recv_idle_pct = 78;
    int   stall_asks    = 0;
    logic chg_run       = 1'b0;
    mv_t  last_mv       = '0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("battery_level_tracker_test: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                book.check_reading('{out_ch.tracked_mv, level_t'(out_ch.charge_level),
                                     out_ch.status_code, out_ch.charging_out,
                                     out_ch.usb_out, out_ch.shutdown_needed});
            if (in_ch.valid && in_ch.ready)
                book.note_sample(in_ch.sample_mv, in_ch.charging_now, in_ch.usb_present);
        end
    end

    initial
    begin : receiver
        int hold_left;
        int asks_seen;
        hold_left    = 0;
        asks_seen    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_asks != asks_seen)
            begin
                asks_seen = stall_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(mv_t mv, logic chg, logic usb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_mv    <= mv;
        in_ch.charging_now <= chg;
        in_ch.usb_present  <= usb;
        last_mv = mv;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, mv_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        book.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic apply_thresholds(mv_t low, mv_t high, mv_t hyst, mv_t shut);
        write_reg(CFG_LOW_THR, low);
        write_reg(CFG_HIGH_THR, high);
        write_reg(CFG_HYST, hyst);
        write_reg(CFG_SHUT_THR, shut);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // aim most samples near a threshold or along a slow drift, so hysteresis is crossed
    task automatic send_random();
        int  v;
        int  pick;
        int  thr;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 12)
            chg_run = ~chg_run;
        if (pick < 5)
            v = 0;
        else if (pick < 15)
            v = $urandom_range(MV_MAX);
        else if (pick < 55)
            v = int'(last_mv) + $urandom_range(60) - 30;
        else
        begin
            case ($urandom_range(2))
                0:       thr = int'(book.low_thr);
                1:       thr = int'(book.high_thr);
                default: thr = int'(book.shut_thr);
            endcase
            v = thr + $urandom_range(2 * int'(book.hyst) + 40) - int'(book.hyst) - 20;
        end
        if (v < 0)
            v = 0;
        if (v > MV_MAX)
            v = MV_MAX;
        send_sample(mv_t'(v), chg_run, 1'($urandom));
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample_mv    = '0;
        in_ch.charging_now = 1'b0;
        in_ch.usb_present  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // discharging: hold the minimum, shutdown at and below its threshold
        send_sample(0, 0, 1);
        send_sample(3500, 0, 1);
        send_sample(3600, 0, 0);
        send_sample(3300, 0, 1);
        send_sample(2900, 0, 0);
        send_sample(0, 0, 0);
        send_sample(3000, 0, 1);
        send_sample(3001, 0, 0);
        // charging: plain rule from unknown, then move only past the band
        send_sample(0, 1, 1);
        send_sample(3400, 1, 1);
        send_sample(3499, 1, 0);
        send_sample(3500, 1, 1);
        send_sample(3301, 1, 1);
        send_sample(3300, 1, 0);
        send_sample(3600, 1, 1);
        send_sample(4049, 1, 1);
        send_sample(4050, 1, 0);
        send_sample(3851, 1, 1);
        send_sample(3850, 1, 1);
        send_sample(4000, 0, 1);
        send_sample(8191, 1, 0);
        send_sample(1, 0, 1);
        send_sample(0, 0, 0);
        stop_sending();
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: apply_thresholds(0, mv_t'(MV_MAX), 1023, mv_t'(MV_MAX));
                1: apply_thresholds(mv_t'(MV_MAX), 0, 0, 0);
                2: apply_thresholds(500, 600, mv_t'(MV_MAX), 550);
                3: apply_thresholds(mv_t'($urandom_range(1000, 4000)),
                                    mv_t'($urandom_range(3500, 5500)),
                                    mv_t'($urandom_range(400)),
                                    mv_t'($urandom_range(2500, 3500)));
                4: apply_thresholds(4000, 4000, 0, 3999);
                default: apply_thresholds(mv_t'(LOW_THR_RESET), mv_t'(HIGH_THR_RESET),
                                          mv_t'(HYST_RESET), mv_t'(SHUT_THR_RESET));
            endcase
            if (ph < 2)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 78;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 5)
                stall_asks <= stall_asks + 1;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                send_random();
                // pause the sender until every result is back
                if (ph == 3 && n == PHASE_BEATS / 2)
                begin
                    stop_sending();
                    wait_drained();
                end
            end
            stop_sending();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("battery_level_tracker_test: done, clean");
        else
            $display("battery_level_tracker_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
